### rtl/core/affine_matrix_inverse_macros.svh
// Assertion macros for the affine matrix inverse block.
// Included by the RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef AFFINE_MATRIX_INVERSE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define AMI_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ami assertion failed");
// Check that a condition implies another in the following cycle.
`define AMI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ami assertion failed");
`else
`define AMI_ASSERT(lbl, cond)
`define AMI_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/core/ami_pkg.sv
// Shared constants for the affine matrix inverse block.
// No dependencies.
package ami_pkg;

  // Elements of the 3x3 linear part, row-major.
  localparam int NumElem = 9;

  // Result row that carries the translation.
  localparam logic [1:0] ROW_LAST = 2'd3;

  // Operand pairs of the cofactor products: cofactor e is
  // m[CofLeft[2e]]*m[CofRight[2e]] - m[CofLeft[2e+1]]*m[CofRight[2e+1]].
  localparam int CofLeft [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int CofRight [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

### rtl/core/affine_matrix_inverse.sv
// Affine transform inverse, row-vector convention, signed fixed point.
// Depends on ami_pkg and affine_matrix_inverse_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per transform: the 3x3
//   linear part and the translation row, each WORD_BITS wide with FRAC_BITS
//   fraction bits. Output channel (out_valid_o / out_stall_i) gives four words
//   per transform: rows 0..2 of the inverse linear part, then the inverse
//   translation row with last_row_o set. singular_o marks a zero determinant
//   (all columns zero); overflow_o marks a row in which an element saturated.
// Throughput: set by the output row serializer, which sends one row per cycle
//   while out_stall_i is low; the arithmetic pipeline itself moves every cycle
//   unless held. The divider is WORD_BITS+1 restoring stages, one quotient bit each.
// Reset: all valid bits clear; no words in flight, out_valid_o low.
// Stall: when the tail stage holds a word and the serializer still holds untaken rows,
//   the whole pipeline holds in place and in_stall_o rises; nothing is lost or repeated.
`include "affine_matrix_inverse_macros.svh"

module affine_matrix_inverse
  import ami_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [WORD_BITS-1:0] lin_r0c0_i,
  input  logic signed [WORD_BITS-1:0] lin_r0c1_i,
  input  logic signed [WORD_BITS-1:0] lin_r0c2_i,
  input  logic signed [WORD_BITS-1:0] lin_r1c0_i,
  input  logic signed [WORD_BITS-1:0] lin_r1c1_i,
  input  logic signed [WORD_BITS-1:0] lin_r1c2_i,
  input  logic signed [WORD_BITS-1:0] lin_r2c0_i,
  input  logic signed [WORD_BITS-1:0] lin_r2c1_i,
  input  logic signed [WORD_BITS-1:0] lin_r2c2_i,
  input  logic signed [WORD_BITS-1:0] trans_x_i,
  input  logic signed [WORD_BITS-1:0] trans_y_i,
  input  logic signed [WORD_BITS-1:0] trans_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  row_index_o,
  output logic signed [WORD_BITS-1:0] col_a_o,
  output logic signed [WORD_BITS-1:0] col_b_o,
  output logic signed [WORD_BITS-1:0] col_c_o,
  output logic                        singular_o,
  output logic                        overflow_o,
  output logic                        last_row_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;       // cofactor product
  localparam int CW = 2 * W + 1;   // cofactor
  localparam int DW = 3 * W + 3;   // determinant
  localparam int QB = W + 1;       // quotient bits
  localparam int RW = DW + QB;     // divider remainder
  localparam int SW = 2 * W + 2;   // translation sum
  localparam int XW = 2 * W + 3;   // magnitudes before saturation
  localparam int NST = 14 + QB;    // pipeline register stages

  typedef struct packed {
    logic [NumElem-1:0][RW-1:0] rem;
    logic [NumElem-1:0][QB-1:0] quo;
    logic [NumElem-1:0]         big;
    logic [NumElem-1:0]         neg;
    logic [DW-1:0]              dmag;
    logic                       sing;
    logic [2:0][W-1:0]          tv;
  } div_t;

  // Saturate a magnitude with its sign to the signed word range: {overflow, value}.
  function automatic logic [W:0] sat_fn(input logic [XW-1:0] mag, input logic neg,
                                        input logic big);
    logic [XW-1:0] lim;
    logic [W-1:0]  v;
    logic          ov;
    lim = XW'(1) << (W - 1);
    if (!neg) lim = lim - XW'(1);
    ov = big || (mag > lim);
    v = neg ? W'(XW'(0) - mag) : W'(mag);
    if (ov) v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return {ov, v};
  endfunction

  logic [NST-1:0] vld_q;
  logic           adv;
  logic           tail_v;

  logic signed [W-1:0]  m_in [NumElem];
  logic signed [W-1:0]  t_in [3];

  logic signed [W-1:0]  m1_q [NumElem];
  logic signed [W-1:0]  t1_q [3];
  logic signed [PW-1:0] pr2_d [18], pr2_q [18];
  logic signed [W-1:0]  mc2_q [3], t2_q [3];
  logic signed [CW-1:0] cf3_d [NumElem], cf3_q [NumElem];
  logic signed [W-1:0]  mc3_q [3], t3_q [3];
  logic signed [CW-1:0] pl4_d [3], ph4_d [3], pl4_q [3], ph4_q [3];
  logic signed [CW-1:0] cf4_q [NumElem];
  logic signed [W-1:0]  t4_q [3];
  logic signed [XW-1:0] dh5_d, dl5_d, dh5_q, dl5_q;
  logic signed [CW-1:0] cf5_q [NumElem];
  logic signed [W-1:0]  t5_q [3];
  logic signed [DW-1:0] det6_d, det6_q;
  logic signed [CW-1:0] cf6_q [NumElem];
  logic signed [W-1:0]  t6_q [3];
  logic [DW-1:0]        dmag7_d, dmag7_q;
  logic                 sing7_d, sing7_q;
  logic [CW-1:0]        cabs7 [NumElem];
  logic [RW-1:0]        n7_d [NumElem], n7_q [NumElem];
  logic                 neg7_d [NumElem], neg7_q [NumElem];
  logic signed [W-1:0]  t7_q [3];

  div_t          div_d [QB+1];
  div_t          div_q [QB+1];
  logic [RW-1:0] sh [QB];

  logic [QB:0]          qr1_d [NumElem], qr1_q [NumElem];
  logic                 rnd1 [NumElem];
  logic                 neg1_q [NumElem], big1_q [NumElem];
  logic                 sing1_q;
  logic signed [W-1:0]  t1p_q [3];
  logic [W:0]           sat2 [NumElem];
  logic signed [W-1:0]  inv2_d [NumElem], inv2_q [NumElem];
  logic [2:0]           ovr2_d, ovr2_q;
  logic                 sing2_q;
  logic signed [W-1:0]  t2p_q [3];
  logic signed [PW-1:0] tp3_d [NumElem], tp3_q [NumElem];
  logic signed [W-1:0]  inv3_q [NumElem];
  logic [2:0]           ovr3_q;
  logic                 sing3_q;
  logic signed [SW-1:0] s4_d [3], s4_q [3];
  logic signed [W-1:0]  inv4_q [NumElem];
  logic [2:0]           ovr4_q;
  logic                 sing4_q;
  logic [SW-1:0]        sabs5 [3];
  logic [XW-1:0]        mag5_d [3], mag5_q [3];
  logic                 rn5_d [3], rn5_q [3];
  logic signed [W-1:0]  inv5_q [NumElem];
  logic [2:0]           ovr5_q;
  logic                 sing5_q;
  logic [W:0]           sat6 [3];
  logic signed [W-1:0]  tr6_d [3], tr6_q [3];
  logic [3:0]           ov6_d, ov6_q;
  logic signed [W-1:0]  inv6_q [NumElem];
  logic                 sing6_q;

  logic [3:0][2:0][W-1:0] so_row_q;
  logic [3:0]             so_ov_q;
  logic                   so_sing_q;
  logic [1:0]             row_q;
  logic                   sv_q;
  logic                   taken, ser_free, load;

  assign m_in = '{lin_r0c0_i, lin_r0c1_i, lin_r0c2_i, lin_r1c0_i, lin_r1c1_i,
                  lin_r1c2_i, lin_r2c0_i, lin_r2c1_i, lin_r2c2_i};
  assign t_in = '{trans_x_i, trans_y_i, trans_z_i};

  // Advance the whole pipeline unless the tail word cannot reach the serializer.
  assign tail_v   = vld_q[NST-1];
  assign taken    = sv_q && !out_stall_i;
  assign ser_free = !sv_q || (taken && row_q == ROW_LAST);
  assign load     = tail_v && ser_free;
  assign adv      = !tail_v || ser_free;
  assign in_stall_o = !adv;

  // Form cofactor products, cofactors, determinant partial products and the determinant.
  always_comb begin
    for (int i = 0; i < 18; i++) pr2_d[i] = m1_q[CofLeft[i]] * m1_q[CofRight[i]];
    for (int e = 0; e < NumElem; e++) cf3_d[e] = CW'(pr2_q[2*e]) - CW'(pr2_q[2*e+1]);
    for (int j = 0; j < 3; j++) begin
      pl4_d[j] = $signed({1'b0, cf3_q[j][W-1:0]}) * mc3_q[j];
      ph4_d[j] = $signed(cf3_q[j][CW-1:W]) * mc3_q[j];
    end
    dh5_d  = XW'(ph4_q[0]) + XW'(ph4_q[1]) + XW'(ph4_q[2]);
    dl5_d  = XW'(pl4_q[0]) + XW'(pl4_q[1]) + XW'(pl4_q[2]);
    det6_d = (DW'(dh5_q) <<< W) + DW'(dl5_q);
  end

  // Take magnitudes and signs ahead of the divider.
  always_comb begin
    dmag7_d = det6_q[DW-1] ? DW'(-det6_q) : DW'(det6_q);
    sing7_d = (det6_q == '0);
    for (int e = 0; e < NumElem; e++) begin
      cabs7[e]  = cf6_q[e][CW-1] ? CW'(-cf6_q[e]) : CW'(cf6_q[e]);
      n7_d[e]   = RW'(cabs7[e]) << (2 * F);
      neg7_d[e] = cf6_q[e][CW-1] ^ det6_q[DW-1];
    end
  end

  // Load the divider and run one restoring step per stage.
  always_comb begin
    div_d[0].dmag = dmag7_q;
    div_d[0].sing = sing7_q;
    for (int r = 0; r < 3; r++) div_d[0].tv[r] = t7_q[r];
    for (int e = 0; e < NumElem; e++) begin
      div_d[0].rem[e] = n7_q[e];
      div_d[0].quo[e] = '0;
      div_d[0].neg[e] = neg7_q[e];
      div_d[0].big[e] = (n7_q[e] >= (RW'(dmag7_q) << QB));
    end
    for (int k = 0; k < QB; k++) begin
      div_d[k+1] = div_q[k];
      sh[k] = RW'(div_q[k].dmag) << (QB - 1 - k);
      for (int e = 0; e < NumElem; e++) begin
        if (div_q[k].rem[e] >= sh[k]) begin
          div_d[k+1].rem[e] = div_q[k].rem[e] - sh[k];
          div_d[k+1].quo[e][QB-1-k] = 1'b1;
        end
      end
    end
  end

  // Round the quotients, saturate, and drop everything on a zero determinant.
  always_comb begin
    for (int e = 0; e < NumElem; e++) begin
      rnd1[e]  = ({div_q[QB].rem[e][DW-1:0], 1'b0} >= {1'b0, div_q[QB].dmag});
      qr1_d[e] = (QB+1)'(div_q[QB].quo[e]) + (QB+1)'(rnd1[e]);
      sat2[e]  = sat_fn(XW'(qr1_q[e]), neg1_q[e], big1_q[e]);
      inv2_d[e] = sing1_q ? '0 : $signed(sat2[e][W-1:0]);
    end
    for (int r = 0; r < 3; r++) begin
      ovr2_d[r] = !sing1_q && (sat2[3*r][W] || sat2[3*r+1][W] || sat2[3*r+2][W]);
    end
  end

  // Form the inverse translation from the saturated linear inverse.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) tp3_d[3*r+c] = t2p_q[r] * inv2_q[3*r+c];
    end
    for (int c = 0; c < 3; c++) begin
      s4_d[c]   = SW'(tp3_q[c]) + SW'(tp3_q[3+c]) + SW'(tp3_q[6+c]);
      sabs5[c]  = s4_q[c][SW-1] ? SW'(-s4_q[c]) : SW'(s4_q[c]);
      mag5_d[c] = (XW'(sabs5[c]) + (XW'(1) << (F - 1))) >> F;
      rn5_d[c]  = !s4_q[c][SW-1] && (s4_q[c] != '0);
      sat6[c]   = sat_fn(mag5_q[c], rn5_q[c], 1'b0);
      tr6_d[c]  = $signed(sat6[c][W-1:0]);
    end
    ov6_d = {sat6[0][W] || sat6[1][W] || sat6[2][W], ovr5_q};
  end

  // Advance the valid bits with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Advance the pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q    <= m_in;
      t1_q    <= t_in;
      pr2_q   <= pr2_d;
      mc2_q   <= '{m1_q[0], m1_q[3], m1_q[6]};
      t2_q    <= t1_q;
      cf3_q   <= cf3_d;
      mc3_q   <= mc2_q;
      t3_q    <= t2_q;
      pl4_q   <= pl4_d;
      ph4_q   <= ph4_d;
      cf4_q   <= cf3_q;
      t4_q    <= t3_q;
      dh5_q   <= dh5_d;
      dl5_q   <= dl5_d;
      cf5_q   <= cf4_q;
      t5_q    <= t4_q;
      det6_q  <= det6_d;
      cf6_q   <= cf5_q;
      t6_q    <= t5_q;
      dmag7_q <= dmag7_d;
      sing7_q <= sing7_d;
      n7_q    <= n7_d;
      neg7_q  <= neg7_d;
      t7_q    <= t6_q;
      div_q   <= div_d;
      qr1_q   <= qr1_d;
      for (int e = 0; e < NumElem; e++) begin
        neg1_q[e] <= div_q[QB].neg[e];
        big1_q[e] <= div_q[QB].big[e];
      end
      sing1_q <= div_q[QB].sing;
      for (int r = 0; r < 3; r++) t1p_q[r] <= $signed(div_q[QB].tv[r]);
      inv2_q  <= inv2_d;
      ovr2_q  <= ovr2_d;
      sing2_q <= sing1_q;
      t2p_q   <= t1p_q;
      tp3_q   <= tp3_d;
      inv3_q  <= inv2_q;
      ovr3_q  <= ovr2_q;
      sing3_q <= sing2_q;
      s4_q    <= s4_d;
      inv4_q  <= inv3_q;
      ovr4_q  <= ovr3_q;
      sing4_q <= sing3_q;
      mag5_q  <= mag5_d;
      rn5_q   <= rn5_d;
      inv5_q  <= inv4_q;
      ovr5_q  <= ovr4_q;
      sing5_q <= sing4_q;
      tr6_q   <= tr6_d;
      ov6_q   <= ov6_d;
      inv6_q  <= inv5_q;
      sing6_q <= sing5_q;
    end
  end

  // Step the serializer through the four rows of the held word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q  <= 1'b0;
      row_q <= '0;
    end else if (load) begin
      sv_q  <= 1'b1;
      row_q <= '0;
    end else if (taken) begin
      row_q <= row_q + 2'd1;
      if (row_q == ROW_LAST) sv_q <= 1'b0;
    end
  end

  // Hold the rows of the word being sent.
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) so_row_q[r][c] <= inv6_q[3*r+c];
      end
      for (int c = 0; c < 3; c++) so_row_q[ROW_LAST][c] <= tr6_q[c];
      so_ov_q   <= ov6_q;
      so_sing_q <= sing6_q;
    end
  end

  assign out_valid_o = sv_q;
  assign row_index_o = row_q;
  assign col_a_o     = $signed(so_row_q[row_q][0]);
  assign col_b_o     = $signed(so_row_q[row_q][1]);
  assign col_c_o     = $signed(so_row_q[row_q][2]);
  assign singular_o  = so_sing_q;
  assign overflow_o  = so_ov_q[row_q];
  assign last_row_o  = (row_q == ROW_LAST);

  `AMI_ASSERT(a_sing_zero, !(sv_q && so_sing_q) || (so_ov_q == '0 && col_a_o == '0 && col_b_o == '0 && col_c_o == '0))
  `AMI_ASSERT_NEXT(a_row_step, taken && row_q != ROW_LAST, sv_q && row_q == $past(row_q) + 2'd1)
  `AMI_ASSERT_NEXT(a_tail_hold, tail_v && !adv, tail_v && $stable(tr6_q[0]))
  `AMI_ASSERT(a_stall_busy, !in_stall_o || (tail_v && sv_q))

endmodule

### dv/tb_top.sv
// Self-checking testbench for affine_matrix_inverse: directed transforms, then random ones.
// Depends on ami_pkg and the affine_matrix_inverse RTL; expected rows come from an own predictor or typed answers.
module tb_top
  import ami_pkg::*;
();

  localparam int W = 32;
  localparam int F = 16;
  localparam int ONE = 32'h0001_0000;
  localparam int WatchdogLimit = 20000;
  localparam int HoldCycles = 400;

  typedef logic signed [255:0] wint_t;
  typedef logic signed [W-1:0] elem_t;
  typedef elem_t xform_t [12];

  typedef struct packed {
    logic [1:0] idx;
    elem_t      a;
    elem_t      b;
    elem_t      c;
    logic       sing;
    logic       ovf;
    logic       last;
  } inv_row_t;

  // Directed rows carry a typed answer where it is obvious
  typedef enum int {ANS_PREDICT, ANS_IDENT, ANS_SINGULAR} answer_e;

  typedef struct {
    xform_t  m;
    answer_e answer;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  elem_t in_elem [12] = '{default: '0};
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] row_index_o;
  elem_t col_a_o, col_b_o, col_c_o;
  logic singular_o, overflow_o, last_row_o;

  inv_row_t inv_rows_q [$];
  int errors = 0;
  int rows_seen = 0;
  int xforms_sent = 0;
  int singular_seen = 0;
  int overflow_seen = 0;
  int idle_pct_send = 0;
  int idle_pct_recv = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  affine_matrix_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .lin_r0c0_i(in_elem[0]), .lin_r0c1_i(in_elem[1]), .lin_r0c2_i(in_elem[2]),
    .lin_r1c0_i(in_elem[3]), .lin_r1c1_i(in_elem[4]), .lin_r1c2_i(in_elem[5]),
    .lin_r2c0_i(in_elem[6]), .lin_r2c1_i(in_elem[7]), .lin_r2c2_i(in_elem[8]),
    .trans_x_i(in_elem[9]), .trans_y_i(in_elem[10]), .trans_z_i(in_elem[11]),
    .out_valid_o, .out_stall_i, .row_index_o, .col_a_o, .col_b_o, .col_c_o,
    .singular_o, .overflow_o, .last_row_o
  );

  // Signed divide, round to nearest, ties away from zero
  function automatic wint_t div_round(wint_t n, wint_t d);
    logic [255:0] un, ud, q, r;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    r = un % ud;
    if ((r << 1) >= ud) q = q + 1;
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  // Clamp to the word range and flag saturation
  function automatic elem_t sat_word(wint_t v, inout logic ovf);
    wint_t hi, lo;
    hi = (wint_t'(1) <<< (W - 1)) - 1;
    lo = -(wint_t'(1) <<< (W - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return elem_t'(hi);
    end
    if (v < lo) begin
      ovf = 1'b1;
      return elem_t'(lo);
    end
    return elem_t'(v);
  endfunction

  // Predict the four inverse rows of one transform
  function automatic void predict_inverse(xform_t x, ref inv_row_t rows [4]);
    wint_t m [9];
    wint_t t [3];
    wint_t adj [9];
    wint_t det, s;
    elem_t inv [9];
    elem_t tr [3];
    logic ovf [4];
    logic sing;
    for (int i = 0; i < 9; i++) m[i] = x[i];
    for (int i = 0; i < 3; i++) t[i] = x[9 + i];
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = adj[0] * m[0] + adj[1] * m[3] + adj[2] * m[6];
    sing = (det == 0);
    for (int k = 0; k < 4; k++) ovf[k] = 1'b0;
    for (int i = 0; i < 9; i++) inv[i] = '0;
    for (int i = 0; i < 3; i++) tr[i] = '0;
    if (!sing) begin
      for (int i = 0; i < 9; i++)
        inv[i] = sat_word(div_round(adj[i] <<< (2 * F), det), ovf[i / 3]);
      for (int c = 0; c < 3; c++) begin
        s = t[0] * wint_t'(inv[c]) + t[1] * wint_t'(inv[3 + c]) + t[2] * wint_t'(inv[6 + c]);
        tr[c] = sat_word(div_round(-s, wint_t'(1) <<< F), ovf[3]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      rows[k].idx = k[1:0];
      rows[k].a = (k < 3) ? inv[3 * k] : tr[0];
      rows[k].b = (k < 3) ? inv[3 * k + 1] : tr[1];
      rows[k].c = (k < 3) ? inv[3 * k + 2] : tr[2];
      rows[k].sing = sing;
      rows[k].ovf = ovf[k];
      rows[k].last = (k[1:0] == ROW_LAST);
    end
  endfunction

  // Queue the expected rows of one accepted word
  task automatic push_rows(vector_t v);
    inv_row_t rows [4];
    if (v.answer == ANS_PREDICT) begin
      predict_inverse(v.m, rows);
    end else begin
      for (int k = 0; k < 4; k++) begin
        rows[k] = '0;
        rows[k].idx = k[1:0];
        rows[k].last = (k[1:0] == ROW_LAST);
        rows[k].sing = (v.answer == ANS_SINGULAR);
        if (v.answer == ANS_IDENT) begin
          if (k < 3) begin
            rows[k].a = (k == 0) ? ONE : 0;
            rows[k].b = (k == 1) ? ONE : 0;
            rows[k].c = (k == 2) ? ONE : 0;
          end else begin
            rows[k].a = -v.m[9];
            rows[k].b = -v.m[10];
            rows[k].c = -v.m[11];
          end
        end
      end
    end
    for (int k = 0; k < 4; k++) inv_rows_q.push_back(rows[k]);
  endtask

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_xform(vector_t v);
    while ($urandom_range(99) < idle_pct_send) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    for (int i = 0; i < 12; i++) in_elem[i] <= v.m[i];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    push_rows(v);
    xforms_sent++;
  endtask

  function automatic vector_t make_vec(xform_t m, answer_e answer);
    vector_t v;
    v.m = m;
    v.answer = answer;
    return v;
  endfunction

  function automatic xform_t ident(elem_t tx, elem_t ty, elem_t tz);
    xform_t m;
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? ONE : 0;
    m[9] = tx;
    m[10] = ty;
    m[11] = tz;
    return m;
  endfunction

  function automatic xform_t fill(elem_t lin, elem_t diag, elem_t tr);
    xform_t m;
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? diag : lin;
    for (int i = 9; i < 12; i++) m[i] = tr;
    return m;
  endfunction

  // Random transform: small-range, near-identity, full-range, singular and tiny-diagonal kinds
  function automatic xform_t rand_xform();
    xform_t m;
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 12; i++) begin
      if (kind < 40) m[i] = $signed($urandom_range(32'h3FFFF)) - 32'sh20000;
      else m[i] = $urandom;
    end
    if (kind >= 40 && kind < 55) begin
      // near identity with full-range translation
      for (int i = 0; i < 9; i++)
        m[i] = ((i % 4 == 0) ? ONE : 0) + $signed($urandom_range(511)) - 256;
    end else if (kind >= 55 && kind < 70) begin
      // repeat a row so the determinant is zero
      for (int c = 0; c < 3; c++) m[6 + c] = m[$urandom_range(1) * 3 + c];
    end else if (kind >= 70 && kind < 78) begin
      // tiny diagonal gives large inverse elements
      for (int i = 0; i < 9; i++)
        m[i] = (i % 4 == 0) ? $signed($urandom_range(64)) - 32 : 0;
    end
    return m;
  endfunction

  // Receiver: long hold on request, else random stall
  always @(posedge clk_i) begin
    int hold_cnt;
    if (hold_req && !hold_done) begin
      hold_cnt++;
      out_stall_i <= 1'b1;
      if (hold_cnt >= HoldCycles) begin
        hold_done <= 1'b1;
        hold_cnt = 0;
      end
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct_recv);
    end
  end

  // Compare each accepted row with the oldest expectation
  always @(posedge clk_i) begin
    inv_row_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{row_index_o, col_a_o, col_b_o, col_c_o, singular_o, overflow_o, last_row_o};
      rows_seen++;
      if (singular_o && row_index_o == ROW_LAST) singular_seen++;
      if (overflow_o) overflow_seen++;
      if (inv_rows_q.size() == 0) begin
        $display("%0t unexpected row: got %p", $time, got);
        errors++;
      end else begin
        want = inv_rows_q.pop_front();
        if (got.idx !== want.idx)
          $display("%0t row_index: expected %0d actual %0d", $time, want.idx, got.idx);
        if (got.a !== want.a)
          $display("%0t col_a: expected %h actual %h", $time, want.a, got.a);
        if (got.b !== want.b)
          $display("%0t col_b: expected %h actual %h", $time, want.b, got.b);
        if (got.c !== want.c)
          $display("%0t col_c: expected %h actual %h", $time, want.c, got.c);
        if (got.sing !== want.sing)
          $display("%0t singular: expected %b actual %b", $time, want.sing, got.sing);
        if (got.ovf !== want.ovf)
          $display("%0t overflow: expected %b actual %b", $time, want.ovf, got.ovf);
        if (got.last !== want.last)
          $display("%0t last_row: expected %b actual %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("affine_matrix_inverse: mismatch");
      $finish;
    end
  end

  initial begin
    vector_t vectors [$];
    int pct_send [4] = '{0, 84, 0, 7};
    int pct_recv [4] = '{0, 0, 84, 7};

    // Directed transforms: identity, extremes, singular cases, saturation
    vectors.push_back(make_vec(ident(0, 0, 0), ANS_IDENT));
    vectors.push_back(make_vec(ident(ONE, 2 * ONE, -3 * ONE), ANS_IDENT));
    vectors.push_back(make_vec(ident(32'sh7FFFFFFF, 32'sh80000001, 1), ANS_IDENT));
    vectors.push_back(make_vec(ident(32'sh80000000, 0, 0), ANS_PREDICT));
    vectors.push_back(make_vec(fill(0, 0, 0), ANS_SINGULAR));
    vectors.push_back(make_vec(fill(32'sh7FFFFFFF, 32'sh7FFFFFFF, 5), ANS_SINGULAR));
    vectors.push_back(make_vec(fill(32'sh80000000, 32'sh80000000, -1), ANS_SINGULAR));
    vectors.push_back(make_vec(fill(0, 1, ONE), ANS_PREDICT));
    vectors.push_back(make_vec(fill(0, -1, 32'sh7FFFFFFF), ANS_PREDICT));
    vectors.push_back(make_vec(fill(0, 32'sh7FFFFFFF, 32'sh80000000), ANS_PREDICT));
    vectors.push_back(make_vec(fill(0, 32'sh80000000, 32'sh7FFFFFFF), ANS_PREDICT));
    vectors.push_back(make_vec(fill(32'sh80000000, 32'sh7FFFFFFF, 3), ANS_PREDICT));
    vectors.push_back(make_vec(fill(ONE, 2 * ONE, -ONE), ANS_PREDICT));
    vectors.push_back(make_vec(fill(32'shFFFFFFFF, 0, 32'h55555555), ANS_PREDICT));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) send_xform(vectors[i]);

    // Random phases; the first one starts with a long receiver hold
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct_send = pct_send[ph];
      idle_pct_recv = pct_recv[ph];
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < 80; n++) send_xform(make_vec(rand_xform(), ANS_PREDICT));
    end
    in_valid_i <= 1'b0;
    idle_pct_recv = 0;

    // Drain, then let the pipeline settle
    while (inv_rows_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d transforms over four idle phases and one long output hold;",
             xforms_sent);
    $display("checked %0d rows, %0d singular transforms, %0d saturated rows.",
             rows_seen, singular_seen, overflow_seen);
    if (errors == 0) begin
      $display("affine_matrix_inverse: match");
    end else begin
      $display("affine_matrix_inverse: mismatch");
    end
    $finish;
  end

endmodule
